### src/ftb42_pkg.sv
// ----------------------------------------------------------------------------
// ftb42_pkg: shared types and constants for the free-text base-42 unpacker
// Payload structs, controller/datapath command and status, and division sizes.
// ----------------------------------------------------------------------------
package ftb42_pkg;

    localparam int RADIX   = 42;
    localparam int VALUE_W = 72;                 // 71-bit text value plus one pad bit
    localparam int CHUNK_W = 8;                  // quotient bits produced per cycle
    localparam int CHUNKS  = VALUE_W / CHUNK_W;
    localparam int STEP_W  = $clog2(CHUNKS);
    localparam int REM_W   = 6;
    localparam int POS_W   = 4;

    typedef struct packed {
        logic [6:0]  value_high;
        logic [63:0] value_low;
    } t_in;

    typedef struct packed {
        logic [POS_W-1:0] char_position;
        logic [REM_W-1:0] symbol_index;
        logic             last_symbol;
    } t_out;

    typedef struct packed {
        logic             load;
        logic             step;
        logic             emit;
        logic [POS_W-1:0] position;
        logic             last;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

### src/free_text_base42_unpack.sv
// ----------------------------------------------------------------------------
// free_text_base42_unpack: free-text base-42 symbol unpacker
// Splits a 71-bit packed text value into character symbol indices, 0 to 41.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one beat per message: the top 7 and low 64 bits
//   of the packed text value. The output channel gives TEXT_CHARS beats per
//   message, position TEXT_CHARS-1 first and position 0 last, flagged by
//   last_symbol. Each beat carries the remainder of one division by 42.
//   Each symbol costs one pass of the shared divide-by-42 unit over the value
//   in 8-bit chunks, then its remainder is loaded into the output register.
//   The input is stalled while a message is in work and opens again once
//   the final beat sits in the output register.
//   Reset clears the controller and drops any pending output beat. A
//   receiver stall holds the current beat; division of the next symbol
//   finishes and then waits until the output register frees up.
// ----------------------------------------------------------------------------
module free_text_base42_unpack #(
    parameter int TEXT_CHARS = 13
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  ftb42_pkg::t_in   i_in,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output ftb42_pkg::t_out  o_out
);

    ftb42_pkg::t_cmd cmd;
    ftb42_pkg::t_sts sts;

    ftb42_ctrl #(
        .TEXT_CHARS (TEXT_CHARS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ftb42_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

### src/ftb42_dp.sv
// ----------------------------------------------------------------------------
// ftb42_dp: division datapath
// Holds the value being reduced, the running remainder and the output beat.
// ----------------------------------------------------------------------------
module ftb42_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ftb42_pkg::t_in   i_in,
    input  ftb42_pkg::t_cmd  i_cmd,
    output ftb42_pkg::t_sts  o_sts,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output ftb42_pkg::t_out  o_out
);

    logic [ftb42_pkg::VALUE_W-1:0] r_val;
    logic [ftb42_pkg::REM_W-1:0]   r_rem;
    logic                          r_out_valid;
    ftb42_pkg::t_out               r_out;

    logic [ftb42_pkg::CHUNK_W-1:0] n_quot;
    logic [ftb42_pkg::REM_W-1:0]   n_rem;

    // Restoring division of (remainder, next chunk) by the radix, one quotient bit per loop iteration.
    always_comb begin
        logic [ftb42_pkg::REM_W:0]     t;
        logic [ftb42_pkg::REM_W-1:0]   r;
        logic [ftb42_pkg::CHUNK_W-1:0] chunk;
        r     = r_rem;
        t     = '0;
        chunk = r_val[ftb42_pkg::VALUE_W-1 -: ftb42_pkg::CHUNK_W];
        for (int i = ftb42_pkg::CHUNK_W - 1; i >= 0; i--) begin
            t = {r, chunk[i]};
            if (t >= (ftb42_pkg::REM_W + 1)'(ftb42_pkg::RADIX)) begin
                n_quot[i] = 1'b1;
                r         = ftb42_pkg::REM_W'(t - (ftb42_pkg::REM_W + 1)'(ftb42_pkg::RADIX));
            end else begin
                n_quot[i] = 1'b0;
                r         = t[ftb42_pkg::REM_W-1:0];
            end
        end
        n_rem = r;
    end

    // The value rotates through by chunks; after a full pass it holds the quotient.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
        end else if (i_cmd.load) begin
            r_val <= {1'b0, i_in.value_high, i_in.value_low};
            r_rem <= '0;
        end else if (i_cmd.step) begin
            r_val <= {r_val[ftb42_pkg::VALUE_W-ftb42_pkg::CHUNK_W-1:0], n_quot};
            r_rem <= n_rem;
        end else if (i_cmd.emit) begin
            r_rem <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid         <= 1'b1;
            r_out.char_position <= i_cmd.position;
            r_out.symbol_index  <= r_rem;
            r_out.last_symbol   <= i_cmd.last;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_out          = r_out;

`ifndef SYNTHESIS
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rem < ftb42_pkg::REM_W'(ftb42_pkg::RADIX))
        else $error("remainder out of range");

    a_sym_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.symbol_index < ftb42_pkg::REM_W'(ftb42_pkg::RADIX))
        else $error("symbol index out of range");

    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.last_symbol == (r_out.char_position == '0)))
        else $error("last flag does not match position zero");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> o_sts.out_free)
        else $error("beat emitted over an unaccepted beat");
`endif

endmodule

### src/ftb42_ctrl.sv
// ----------------------------------------------------------------------------
// ftb42_ctrl: sequencing controller
// Steps chunk divisions per symbol and counts character positions down.
// ----------------------------------------------------------------------------
module ftb42_ctrl #(
    parameter int TEXT_CHARS = 13
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  ftb42_pkg::t_sts  i_sts,
    output ftb42_pkg::t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } t_state;

    t_state                          r_state;
    logic [ftb42_pkg::STEP_W-1:0]    r_step;
    logic [ftb42_pkg::POS_W-1:0]     r_pos;

    always_comb begin
        o_cmd.load     = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.step     = (r_state == ST_DIV);
        o_cmd.emit     = (r_state == ST_EMIT) && i_sts.out_free;
        o_cmd.position = r_pos;
        o_cmd.last     = (r_pos == '0);
    end

    assign o_in_stall = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_pos   <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= ST_DIV;
                        r_step  <= '0;
                        r_pos   <= ftb42_pkg::POS_W'(TEXT_CHARS - 1);
                    end
                end
                ST_DIV: begin
                    if (r_step == ftb42_pkg::STEP_W'(ftb42_pkg::CHUNKS - 1)) begin
                        r_state <= ST_EMIT;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                ST_EMIT: begin
                    if (i_sts.out_free) begin
                        if (r_pos == '0) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_state <= ST_DIV;
                            r_step  <= '0;
                            r_pos   <= r_pos - 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= ftb42_pkg::STEP_W'(ftb42_pkg::CHUNKS - 1))
        else $error("chunk counter overran");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_IDLE |-> r_pos <= ftb42_pkg::POS_W'(TEXT_CHARS - 1))
        else $error("position counter out of range");

    a_div_to_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && r_step == ftb42_pkg::STEP_W'(ftb42_pkg::CHUNKS - 1))
        |=> r_state == ST_EMIT)
        else $error("symbol not emitted after a full division pass");
`endif

endmodule
